/* hw/rtl/arpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the address-resolution table engine.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_BITS = $clog2(ENTRIES);
    localparam int TAG_BITS = 8;

    localparam logic [31:0] DEFAULT_LIFETIME = 32'd12000;

    localparam logic [1:0] MODE_RESOLVE = 2'd0;
    localparam logic [1:0] MODE_LEARN   = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic [2:0] KIND_HIT     = 3'd0;
    localparam logic [2:0] KIND_REQUEST = 3'd1;
    localparam logic [2:0] KIND_DROP    = 3'd2;
    localparam logic [2:0] KIND_RELEASE = 3'd3;
    localparam logic [2:0] KIND_REPLY   = 3'd4;

    localparam logic [1:0] CFG_OUR_IP   = 2'd0;
    localparam logic [1:0] CFG_OUR_MAC  = 2'd1;
    localparam logic [1:0] CFG_LIFETIME = 2'd2;

    localparam logic [15:0] REQ_OPCODE = 16'd1;

    typedef struct packed {
        logic [31:0]         ip;
        logic [47:0]         mac;
        logic                valid;
        logic [63:0]         expiry;
        logic                pend;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic                active;
        logic [31:0]         key;
        logic                hit;
        logic [IDX_BITS-1:0] hit_idx;
        logic                hit_valid;
        logic [47:0]         hit_mac;
        logic                hit_pend;
        logic [TAG_BITS-1:0] hit_tag;
        logic                free;
        logic [IDX_BITS-1:0] free_idx;
        logic                expd;
        logic [IDX_BITS-1:0] exp_idx;
        logic                nopend;
        logic [IDX_BITS-1:0] np_idx;
        logic [TAG_BITS-1:0] tag0;
    } scan_t;

    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] idx;
        logic                upd_addr;
        logic                upd_learn;
        entry_t              data;
    } wr_t;

    typedef struct packed {
        logic [2:0]          kind;
        logic [47:0]         mac;
        logic [31:0]         ip;
        logic [TAG_BITS-1:0] tag;
    } result_t;

endpackage

/* hw/rtl/arp_cache_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_engine
// Address-resolution table: a row of slot cells searched by a passing word.
// ----------------------------------------------------------------------------
// A resolve or received-packet word is registered; its search word then
// crosses every cell's register before the results are registered. No new
// word is taken until all results are taken; a tick word starts no search.
// Reset clears all slots, tick count, registers; lifetime gets its default.
module arp_cache_engine
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic [31:0]                   ip_addr,
    input  logic                          has_pending,
    input  logic [arpc_pkg::TAG_BITS-1:0] pending_tag,
    input  logic [47:0]                   sender_mac,
    input  logic [31:0]                   tgt_ip,
    input  logic [15:0]                   arp_op,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    kind,
    output logic [47:0]                   mac_addr,
    output logic [31:0]                   ip_out,
    output logic [arpc_pkg::TAG_BITS-1:0] tag_out,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_idx,
    input  logic [47:0]                   cfg_data
);

    typedef enum logic [1:0] { S_IDLE, S_SCAN, S_EMIT } state_t;

    state_t                          state_reg;
    logic [31:0]                     our_ip_reg;
    logic [47:0]                     our_mac_reg;
    logic [31:0]                     lifetime_reg;
    logic [63:0]                     tick_reg;
    logic                            launch_reg;
    logic [1:0]                      mode_reg;
    logic [31:0]                     ip_reg;
    logic                            hp_reg;
    logic [arpc_pkg::TAG_BITS-1:0]   tag_reg;
    logic [47:0]                     smac_reg;
    logic [31:0]                     tip_reg;
    logic [15:0]                     op_reg;
    arpc_pkg::result_t               res_reg [2];
    logic [1:0]                      cnt_reg;
    logic                            ptr_reg;
    arpc_pkg::wr_t                   wr_reg;

    arpc_pkg::scan_t                 head;
    arpc_pkg::scan_t                 chain [arpc_pkg::ENTRIES+1];
    arpc_pkg::scan_t                 fin;
    arpc_pkg::result_t               res_next [2];
    logic [1:0]                      cnt_next;
    arpc_pkg::wr_t                   wr_next;
    logic [arpc_pkg::IDX_BITS-1:0]   slot;
    logic                            drop0;

    always_comb
    begin
        head        = '0;
        head.active = launch_reg;
        head.key    = ip_reg;
    end

    assign chain[0] = head;

    genvar g;
    generate
        for (g = 0; g < arpc_pkg::ENTRIES; g++)
        begin : g_cell
            arpc_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (arpc_pkg::IDX_BITS'(g)),
                .tick     (tick_reg),
                .scan_in  (chain[g]),
                .scan_out (chain[g+1]),
                .wr       (wr_reg)
            );
        end
    endgenerate

    assign fin   = chain[arpc_pkg::ENTRIES];
    assign drop0 = !fin.free && !fin.expd && !fin.nopend;

    always_comb
    begin
        if (fin.free)
            slot = fin.free_idx;
        else if (fin.expd)
            slot = fin.exp_idx;
        else if (fin.nopend)
            slot = fin.np_idx;
        else
            slot = '0;
    end

    always_comb
    begin
        res_next[0] = '0;
        res_next[1] = '0;
        cnt_next    = 2'd0;
        wr_next     = '0;
        if (mode_reg == arpc_pkg::MODE_RESOLVE)
        begin
            if (fin.hit && fin.hit_valid)
            begin
                res_next[0] = '{arpc_pkg::KIND_HIT, fin.hit_mac, ip_reg, '0};
                cnt_next    = 2'd1;
            end
            else
            begin
                if (!fin.hit && drop0)
                begin
                    res_next[cnt_next[0]] = '{arpc_pkg::KIND_DROP, 48'd0, 32'd0, fin.tag0};
                    cnt_next = cnt_next + 2'd1;
                end
                if (fin.hit && fin.hit_pend && hp_reg)
                begin
                    res_next[cnt_next[0]] = '{arpc_pkg::KIND_DROP, 48'd0, 32'd0, fin.hit_tag};
                    cnt_next = cnt_next + 2'd1;
                end
                res_next[cnt_next[0]] = '{arpc_pkg::KIND_REQUEST, 48'd0, ip_reg, '0};
                cnt_next = cnt_next + 2'd1;
                wr_next.idx        = fin.hit ? fin.hit_idx : slot;
                wr_next.upd_addr   = !fin.hit;
                wr_next.data.ip    = ip_reg;
                wr_next.data.valid = 1'b0;
                wr_next.en         = !fin.hit || hp_reg;
                wr_next.data.pend  = hp_reg;
                wr_next.data.tag   = hp_reg ? tag_reg : '0;
            end
        end
        else
        begin
            if (!fin.hit && drop0)
            begin
                res_next[0] = '{arpc_pkg::KIND_DROP, 48'd0, 32'd0, fin.tag0};
                cnt_next    = 2'd1;
            end
            if (fin.hit && fin.hit_pend)
            begin
                res_next[0] = '{arpc_pkg::KIND_RELEASE, smac_reg, 32'd0, fin.hit_tag};
                cnt_next    = 2'd1;
            end
            if (op_reg == arpc_pkg::REQ_OPCODE && tip_reg == our_ip_reg)
            begin
                res_next[cnt_next[0]] = '{arpc_pkg::KIND_REPLY, smac_reg, ip_reg, '0};
                cnt_next = cnt_next + 2'd1;
            end
            wr_next.en          = 1'b1;
            wr_next.idx         = fin.hit ? fin.hit_idx : slot;
            wr_next.upd_addr    = 1'b1;
            wr_next.upd_learn   = 1'b1;
            wr_next.data.ip     = ip_reg;
            wr_next.data.mac    = smac_reg;
            wr_next.data.valid  = 1'b1;
            wr_next.data.expiry = tick_reg + {32'd0, lifetime_reg};
            wr_next.data.pend   = 1'b0;
            wr_next.data.tag    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            our_ip_reg   <= '0;
            our_mac_reg  <= '0;
            lifetime_reg <= arpc_pkg::DEFAULT_LIFETIME;
            tick_reg     <= '0;
            launch_reg   <= 1'b0;
            mode_reg     <= arpc_pkg::MODE_RESOLVE;
            ip_reg       <= '0;
            hp_reg       <= 1'b0;
            tag_reg      <= '0;
            smac_reg     <= '0;
            tip_reg      <= '0;
            op_reg       <= '0;
            res_reg[0]   <= '0;
            res_reg[1]   <= '0;
            cnt_reg      <= '0;
            ptr_reg      <= 1'b0;
            wr_reg       <= '0;
        end
        else
        begin
            launch_reg <= 1'b0;
            wr_reg.en  <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_idx)
                    arpc_pkg::CFG_OUR_IP:   our_ip_reg   <= cfg_data[31:0];
                    arpc_pkg::CFG_OUR_MAC:  our_mac_reg  <= cfg_data;
                    arpc_pkg::CFG_LIFETIME: lifetime_reg <= cfg_data[31:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg <= mode;
                        ip_reg   <= ip_addr;
                        hp_reg   <= has_pending;
                        tag_reg  <= pending_tag;
                        smac_reg <= sender_mac;
                        tip_reg  <= tgt_ip;
                        op_reg   <= arp_op;
                        if (mode == arpc_pkg::MODE_RESOLVE || mode == arpc_pkg::MODE_LEARN)
                        begin
                            launch_reg <= 1'b1;
                            state_reg  <= S_SCAN;
                        end
                        else if (mode == arpc_pkg::MODE_TICK)
                        begin
                            tick_reg <= tick_reg + 64'd1;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (fin.active)
                    begin
                        res_reg[0] <= res_next[0];
                        res_reg[1] <= res_next[1];
                        cnt_reg    <= cnt_next;
                        ptr_reg    <= 1'b0;
                        wr_reg     <= wr_next;
                        state_reg  <= (cnt_next == 2'd0) ? S_IDLE : S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        ptr_reg <= 1'b1;
                        if (last)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign kind      = res_reg[ptr_reg].kind;
    assign mac_addr  = res_reg[ptr_reg].mac;
    assign ip_out    = res_reg[ptr_reg].ip;
    assign tag_out   = res_reg[ptr_reg].tag;
    assign last      = ({1'b0, ptr_reg} + 2'd1 == cnt_reg);

`ifndef ASSERT_OFF
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output both open");
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        fin.active |-> state_reg == S_SCAN)
        else $error("search word ended outside scan");
    a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cnt_reg == 2'd1 || cnt_reg == 2'd2))
        else $error("emit with bad result count");
    a_write_after: assert property (@(posedge clk) disable iff (!rst_n)
        wr_reg.en |-> $past(fin.active))
        else $error("slot write without finished search");
`endif

endmodule

/* hw/rtl/arpc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_cell
// One table slot; folds its entry into the search word passing down the row.
// ----------------------------------------------------------------------------
module arpc_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [arpc_pkg::IDX_BITS-1:0] cell_idx,
    input  logic [63:0]                   tick,
    input  arpc_pkg::scan_t               scan_in,
    output arpc_pkg::scan_t               scan_out,
    input  arpc_pkg::wr_t                 wr
);

    arpc_pkg::entry_t ent_reg;
    arpc_pkg::scan_t  scan_reg;
    arpc_pkg::scan_t  scan_next;

    always_comb
    begin
        scan_next = scan_in;
        if (!scan_in.hit && ent_reg.ip == scan_in.key && (ent_reg.valid || ent_reg.pend))
        begin
            scan_next.hit       = 1'b1;
            scan_next.hit_idx   = cell_idx;
            scan_next.hit_valid = ent_reg.valid;
            scan_next.hit_mac   = ent_reg.mac;
            scan_next.hit_pend  = ent_reg.pend;
            scan_next.hit_tag   = ent_reg.tag;
        end
        if (!scan_in.free && !ent_reg.valid && !ent_reg.pend)
        begin
            scan_next.free     = 1'b1;
            scan_next.free_idx = cell_idx;
        end
        if (!scan_in.expd && ent_reg.valid && (ent_reg.expiry < tick) && !ent_reg.pend)
        begin
            scan_next.expd    = 1'b1;
            scan_next.exp_idx = cell_idx;
        end
        if (!scan_in.nopend && !ent_reg.pend)
        begin
            scan_next.nopend = 1'b1;
            scan_next.np_idx = cell_idx;
        end
        if (cell_idx == '0)
        begin
            scan_next.tag0 = ent_reg.tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
            ent_reg  <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
            if (wr.en && wr.idx == cell_idx)
            begin
                if (wr.upd_addr)
                begin
                    ent_reg.ip    <= wr.data.ip;
                    ent_reg.valid <= wr.data.valid;
                end
                if (wr.upd_learn)
                begin
                    ent_reg.mac    <= wr.data.mac;
                    ent_reg.expiry <= wr.data.expiry;
                end
                ent_reg.pend <= wr.data.pend;
                ent_reg.tag  <= wr.data.tag;
            end
        end
    end

    assign scan_out = scan_reg;

endmodule
